// File: hdl/serial_setpoint_command_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial setpoint command parser
// Clocked, reset-qualified checks for the asserting module, sspc_parser.
// ---------------------------------------------------------------------------
`ifndef SERIAL_SETPOINT_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_SETPOINT_COMMAND_PARSER_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define SSPC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sspc_pkg.sv
// ---------------------------------------------------------------------------
// sspc_pkg
// Shared constants, types and helpers for the setpoint command parser.
// ---------------------------------------------------------------------------
package sspc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int EXT_BITS   = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [VALUE_BITS-1:0] DECIMAL_BASE = VALUE_BITS'(10);

    localparam logic [2:0] START_LEN = 3'd5;
    localparam logic [2:0] STOP_LEN  = 3'd4;
    localparam logic [2:0] POS_MAX   = 3'd5;

    localparam logic [2:0] FIELD_LOW   = 3'd1;
    localparam logic [2:0] FIELD_HIGH  = 3'd2;
    localparam logic [2:0] FIELD_PWM   = 3'd3;
    localparam logic [2:0] FIELD_MAX   = 3'd7;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic                       running;
        logic signed [OUT_BITS-1:0] low_threshold;
        logic signed [OUT_BITS-1:0] high_threshold;
        logic signed [OUT_BITS-1:0] pwm_rate;
        logic                       message_end;
    } result_t;

    function automatic logic [7:0] start_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h73; // s
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h72; // r
            3'd4:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] stop_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h73; // s
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h6F; // o
            3'd3:    c = 8'h70; // p
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Sign-extend or truncate a setpoint to the output width
    function automatic logic signed [OUT_BITS-1:0] to_out(input value_t v);
        logic signed [EXT_BITS-1:0] e;
        e = EXT_BITS'($signed(v));
        return e[OUT_BITS-1:0];
    endfunction

endpackage

// File: hdl/sspc_in_stage.sv
// ---------------------------------------------------------------------------
// sspc_in_stage
// Input register for received bytes, loaded whenever it empties downstream.
// ---------------------------------------------------------------------------
module sspc_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // Stalled only while a held byte cannot move on this cycle
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// File: hdl/sspc_parser.sv
// ---------------------------------------------------------------------------
// sspc_parser
// Message and field state; one byte is folded in per advance.
// ---------------------------------------------------------------------------
module sspc_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        byte_data,
    output sspc_pkg::result_t result
);
    import sspc_pkg::*;

    `include "serial_setpoint_command_parser_assert.svh"

    logic [2:0] pos_reg,        pos_next;
    logic       start_reg,      start_next;
    logic       stop_reg,       stop_next;
    logic [2:0] field_reg,      field_next;
    value_t     acc_reg,        acc_next;
    logic       neg_reg,        neg_next;
    logic       closed_reg,     closed_next;
    logic       seen_reg,       seen_next;
    logic       running_reg,    running_next;
    value_t     low_reg,        low_next;
    value_t     high_reg,       high_next;
    value_t     pwm_reg,        pwm_next;

    logic       is_end;
    logic       is_digit;
    value_t     field_value;
    value_t     acc_scaled;
    value_t     digit_value;

    assign is_end      = (byte_data == CHAR_HASH);
    assign field_value = neg_reg ? (-acc_reg) : acc_reg;
    assign acc_scaled  = VALUE_BITS'(acc_reg * DECIMAL_BASE);
    assign digit_value = VALUE_BITS'(byte_data - CHAR_ZERO);

    always_comb
    begin
        is_digit     = byte_data inside {[CHAR_ZERO:CHAR_NINE]};
        pos_next     = pos_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        field_next   = field_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        closed_next  = closed_reg;
        seen_next    = seen_reg;
        running_next = running_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        pwm_next     = pwm_reg;

        if (is_end)
        begin
            if (pos_reg >= START_LEN && start_reg)
            begin
                running_next = 1'b1;
            end
            else if (pos_reg >= STOP_LEN && stop_reg)
            begin
                running_next = 1'b0;
            end
            pos_next    = '0;
            start_next  = 1'b1;
            stop_next   = 1'b1;
            field_next  = '0;
            acc_next    = '0;
            neg_next    = 1'b0;
            closed_next = 1'b0;
            seen_next   = 1'b0;
        end
        else
        begin
            if (pos_reg < START_LEN && byte_data != start_char(pos_reg))
            begin
                start_next = 1'b0;
            end
            if (pos_reg < STOP_LEN && byte_data != stop_char(pos_reg))
            begin
                stop_next = 1'b0;
            end
            if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + 3'd1;
            end

            if (byte_data == CHAR_COMMA)
            begin
                case (field_reg)
                    FIELD_LOW:  low_next  = field_value;
                    FIELD_HIGH: high_next = field_value;
                    FIELD_PWM:  pwm_next  = field_value;
                    default:    ;
                endcase
                if (field_reg < FIELD_MAX)
                begin
                    field_next = field_reg + 3'd1;
                end
                acc_next    = '0;
                neg_next    = 1'b0;
                closed_next = 1'b0;
                seen_next   = 1'b0;
            end
            else
            begin
                if (!seen_reg && byte_data == CHAR_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (is_digit && !closed_reg)
                begin
                    acc_next = acc_scaled + digit_value;
                end
                else
                begin
                    closed_next = 1'b1;
                end
                seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            start_reg   <= 1'b1;
            stop_reg    <= 1'b1;
            field_reg   <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            closed_reg  <= 1'b0;
            seen_reg    <= 1'b0;
            running_reg <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            pwm_reg     <= '0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            stop_reg    <= stop_next;
            field_reg   <= field_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            closed_reg  <= closed_next;
            seen_reg    <= seen_next;
            running_reg <= running_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            pwm_reg     <= pwm_next;
        end
    end

    // Result reflects the state after this byte
    assign result.running        = running_next;
    assign result.low_threshold  = to_out(low_next);
    assign result.high_threshold = to_out(high_next);
    assign result.pwm_rate       = to_out(pwm_next);
    assign result.message_end    = is_end;

    `SSPC_ASSERT_ALWAYS(a_pos_range, pos_reg <= POS_MAX, "char position beyond saturation")
    `SSPC_ASSERT_ALWAYS(a_closed_seen, !closed_reg || seen_reg, "digits closed in empty field")
    `SSPC_ASSERT_NEXT(a_end_clears, advance && is_end,
        pos_reg == 3'd0 && field_reg == 3'd0 && start_reg && stop_reg && !seen_reg,
        "terminator did not clear message state")
    `SSPC_ASSERT_NEXT(a_hold_setpoints, !advance,
        $stable(low_reg) && $stable(high_reg) && $stable(pwm_reg) && $stable(running_reg),
        "setpoints changed without a byte")

endmodule

// File: hdl/serial_setpoint_command_parser.sv
// ---------------------------------------------------------------------------
// serial_setpoint_command_parser
// Parses '#'-terminated setpoint and start/stop messages from serial bytes.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------------
//  input    | in  | in_valid / in_stall  | rx_byte
//  result   | out | out_valid / out_stall| running, low_threshold, high_threshold,
//           |     |                      | pwm_rate, message_end
//
//  One byte per cycle sustained while out_stall is low; each byte passes
//  through the input register, then the parser logic, then the result
//  register, from which its result is transferred.
//  Each byte yields exactly one result.
//  rst_n clears the parser state, setpoints and both valid flags.
//  While out_stall holds a result, one more byte is taken into the input
//  register; in_stall then rises until the result is transferred.
// ---------------------------------------------------------------------------
module serial_setpoint_command_parser
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               running,
    output logic signed [sspc_pkg::OUT_BITS-1:0] low_threshold,
    output logic signed [sspc_pkg::OUT_BITS-1:0] high_threshold,
    output logic signed [sspc_pkg::OUT_BITS-1:0] pwm_rate,
    output logic                               message_end
);
    import sspc_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       advance;
    logic       out_load;
    result_t    result;
    result_t    result_reg;
    logic       out_valid_reg;

    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = byte_valid && out_load;

    sspc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sspc_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign running        = result_reg.running;
    assign low_threshold  = result_reg.low_threshold;
    assign high_threshold = result_reg.high_threshold;
    assign pwm_rate       = result_reg.pwm_rate;
    assign message_end    = result_reg.message_end;

endmodule

// File: bench/serial_setpoint_command_parser_tb.sv
// ---------------------------------------------------------------------------
// serial_setpoint_command_parser_tb
// Drives serial bytes through the command parser and predicts each result
// from a behavioural copy of the parser state. The bench starts with a short
// fixed sequence and then sends random start/stop/setpoint messages mixed
// with noise. Random idling on both channels is added, except in the last
// part of the run.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module serial_setpoint_command_parser_tb;

    import sspc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam string START_TEXT = "start";
    localparam string STOP_TEXT  = "stop";

    typedef struct {
        logic [7:0] ch;
        bit         lit;
        result_t    want;
    } stim_row_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [7:0]                   rx_byte   = 8'h00;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         running;
    logic signed [OUT_BITS-1:0]   low_threshold;
    logic signed [OUT_BITS-1:0]   high_threshold;
    logic signed [OUT_BITS-1:0]   pwm_rate;
    logic                         message_end;

    // parser state as the predictor sees it
    logic [2:0] msg_pos;
    logic       start_ok;
    logic       stop_ok;
    logic [2:0] field_idx;
    value_t     field_acc;
    logic       field_neg;
    logic       field_done;
    logic       field_seen;
    logic       run_state;
    value_t     sp_low;
    value_t     sp_high;
    value_t     sp_pwm;

    result_t     expected_q[$];
    result_t     oldest;
    stim_row_t   dir_rows[$];
    logic [7:0]  msg_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    int unsigned stall_left = 0;
    int unsigned fails      = 0;

    serial_setpoint_command_parser uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running        (running),
        .low_threshold  (low_threshold),
        .high_threshold (high_threshold),
        .pwm_rate       (pwm_rate),
        .message_end    (message_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_field();
        field_acc  = '0;
        field_neg  = 1'b0;
        field_done = 1'b0;
        field_seen = 1'b0;
    endfunction

    function automatic void clear_message();
        msg_pos   = '0;
        start_ok  = 1'b1;
        stop_ok   = 1'b1;
        field_idx = '0;
        clear_field();
    endfunction

    // Advance the parser state by one byte and return the setpoints after it
    function automatic result_t parse_byte(input logic [7:0] ch);
        result_t r;
        value_t  v;
        r.message_end = 1'b0;
        if (ch == CHAR_HASH)
        begin
            r.message_end = 1'b1;
            if (msg_pos >= START_LEN && start_ok)
                run_state = 1'b1;
            else if (msg_pos >= STOP_LEN && stop_ok)
                run_state = 1'b0;
            clear_message();
        end
        else
        begin
            if (msg_pos < START_LEN && ch != START_TEXT[msg_pos])
                start_ok = 1'b0;
            if (msg_pos < STOP_LEN && ch != STOP_TEXT[msg_pos])
                stop_ok = 1'b0;
            if (msg_pos < POS_MAX)
                msg_pos = msg_pos + 3'd1;
            if (ch == CHAR_COMMA)
            begin
                v = field_neg ? -field_acc : field_acc;
                if (field_idx == FIELD_LOW)
                    sp_low = v;
                else if (field_idx == FIELD_HIGH)
                    sp_high = v;
                else if (field_idx == FIELD_PWM)
                    sp_pwm = v;
                if (field_idx < FIELD_MAX)
                    field_idx = field_idx + 3'd1;
                clear_field();
            end
            else
            begin
                if (!field_seen && ch == CHAR_MINUS)
                    field_neg = 1'b1;
                else if (ch >= CHAR_ZERO && ch <= CHAR_NINE && !field_done)
                    field_acc = field_acc * DECIMAL_BASE + value_t'(ch - CHAR_ZERO);
                else
                    field_done = 1'b1;
                field_seen = 1'b1;
            end
        end
        r.running        = run_state;
        r.low_threshold  = to_out(sp_low);
        r.high_threshold = to_out(sp_high);
        r.pwm_rate       = to_out(sp_pwm);
        return r;
    endfunction

    function automatic void add_text(input string s);
        stim_row_t row;
        for (int i = 0; i < s.len(); i++)
        begin
            row.ch   = s[i];
            row.lit  = 1'b0;
            row.want = '0;
            dir_rows.push_back(row);
        end
    endfunction

    function automatic void add_lit(input logic [7:0] ch, input result_t want);
        stim_row_t row;
        row.ch   = ch;
        row.lit  = 1'b1;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] any_letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // One field: optional sign, some digits, then perhaps something that
    // closes the digits early
    function automatic void push_field();
        int unsigned ndig;
        if ($urandom_range(0, 2) == 0)
            msg_bytes.push_back(CHAR_MINUS);
        ndig = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        repeat (ndig)
            msg_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 7))
            0:
            begin
                msg_bytes.push_back(CHAR_MINUS);
                msg_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            1:
            begin
                msg_bytes.push_back(any_letter());
                msg_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            2:       msg_bytes.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
    endfunction

    function automatic void make_message();
        string word;
        int unsigned pos;
        int unsigned nfields;
        if ($urandom_range(0, 7) == 0)
        begin
            // raw noise, no framing
            repeat ($urandom_range(1, 8))
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        word = $urandom_range(0, 1) ? START_TEXT : STOP_TEXT;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: push_text(word);
            6:  push_text(word.substr(0, $urandom_range(0, word.len() - 2)));
            7:
            begin
                pos = $urandom_range(0, word.len() - 1);
                word[pos] = any_letter();
                push_text(word);
            end
            8:
            begin
                repeat ($urandom_range(1, 6))
                    msg_bytes.push_back(any_letter());
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                msg_bytes.push_back(any_letter());
        end
        nfields = $urandom_range(0, 9);
        repeat (nfields)
        begin
            msg_bytes.push_back(CHAR_COMMA);
            push_field();
        end
        msg_bytes.push_back(CHAR_HASH);
    endfunction

    task automatic send_byte(input logic [7:0] ch, input bit lit, input result_t want);
        result_t pred;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = parse_byte(ch);
        expected_q.push_back(lit ? want : pred);
        bytes_sent++;
    endtask

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(1, 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fails++;
            end
            else
            begin
                oldest = expected_q.pop_front();
                if (running !== oldest.running)
                begin
                    $error("running: expected %0d, got %0d", oldest.running, running);
                    fails++;
                end
                if (low_threshold !== oldest.low_threshold)
                begin
                    $error("low_threshold: expected %0d, got %0d",
                           oldest.low_threshold, low_threshold);
                    fails++;
                end
                if (high_threshold !== oldest.high_threshold)
                begin
                    $error("high_threshold: expected %0d, got %0d",
                           oldest.high_threshold, high_threshold);
                    fails++;
                end
                if (pwm_rate !== oldest.pwm_rate)
                begin
                    $error("pwm_rate: expected %0d, got %0d", oldest.pwm_rate, pwm_rate);
                    fails++;
                end
                if (message_end !== oldest.message_end)
                begin
                    $error("message_end: expected %0d, got %0d",
                           oldest.message_end, message_end);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int unsigned total;
        int unsigned next_reroll;
        clear_message();
        run_state = 1'b0;
        sp_low    = '0;
        sp_high   = '0;
        sp_pwm    = '0;

        // Fixed sequence: start, a stop that is one character short, then a
        // stop carrying setpoints with a late minus, a field closed by a
        // non-digit and an open field discarded at the terminator.
        add_lit("s", result_t'{1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0});
        add_text("tart");
        add_lit(CHAR_HASH, result_t'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1});
        add_text("sto");
        add_lit(CHAR_HASH, result_t'{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1});
        add_text("stop,-9,3-5,");
        add_lit(8'hFF, result_t'{1'b1, -16'sd9, 16'sd3, 16'sd0, 1'b0});
        add_text("7,8");
        add_lit(8'h00, result_t'{1'b1, -16'sd9, 16'sd3, 16'sd0, 1'b0});
        add_lit(CHAR_HASH, result_t'{1'b0, -16'sd9, 16'sd3, 16'sd0, 1'b1});

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 10;
        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].lit, dir_rows[i].want);

        total       = dir_rows.size() + RANDOM_ITEMS;
        next_reroll = 0;
        while (bytes_sent < total)
        begin
            if (bytes_sent + QUIET_ITEMS >= total)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (bytes_sent >= next_reroll)
            begin
                // vary the pressure so that some stretches run flat out
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 5;
                    2:       gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    2:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
                next_reroll = bytes_sent + 80;
            end
            make_message();
            while (msg_bytes.size() != 0)
                send_byte(msg_bytes.pop_front(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/sspc_pkg.sv
hdl/sspc_in_stage.sv
hdl/sspc_parser.sv
hdl/serial_setpoint_command_parser.sv
bench/serial_setpoint_command_parser_tb.sv
